### rtl/ccrc_pkg.sv
`timescale 1ns / 1ps

package ccrc_pkg;

	localparam int CRC_W = 32;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		WMODE_8  = 2'd0,
		WMODE_16 = 2'd1,
		WMODE_32 = 2'd2,
		WMODE_SAT = 2'd3
	} wmode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH_MODE  = 3'd0,
		REG_INITIAL     = 3'd1,
		REG_POLYNOMIAL  = 3'd2,
		REG_FINAL_XOR   = 3'd3,
		REG_REFLECT_IN  = 3'd4,
		REG_REFLECT_OUT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		wmode_t             width_mode;
		logic [CRC_W-1:0]   preset_value;
		logic [CRC_W-1:0]   polynomial;
		logic [CRC_W-1:0]   final_xor_value;
		logic               reflect_input;
		logic               reflect_output;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [CRC_W-1:0]   crc;
		logic               last;
	} result_t;

	function automatic logic [4:0] align_shift(input wmode_t mode);
		logic [4:0] sh;
		case (mode)
			WMODE_8:  sh = 5'd24;
			WMODE_16: sh = 5'd16;
			default:  sh = 5'd0;
		endcase
		return sh;
	endfunction

	function automatic logic [CRC_W-1:0] width_mask(input wmode_t mode);
		logic [CRC_W-1:0] m;
		case (mode)
			WMODE_8:  m = 32'h0000_00FF;
			WMODE_16: m = 32'h0000_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] x);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = x[7-i];
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] reverse_word(input logic [CRC_W-1:0] x);
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = x[CRC_W-1-i];
		end
		return r;
	endfunction

	// work top-aligned so the feedback bit is always the msb
	function automatic logic [CRC_W-1:0] crc_byte(
		input logic [CRC_W-1:0] crc,
		input logic [7:0]       data,
		input logic [CRC_W-1:0] poly,
		input wmode_t           mode
	);
		logic [CRC_W-1:0] a;
		logic [CRC_W-1:0] p;
		logic [4:0]       sh;
		sh = align_shift(mode);
		a = (crc & width_mask(mode)) << sh;
		a = a ^ {data, {(CRC_W-8){1'b0}}};
		p = (poly & width_mask(mode)) << sh;
		for (int i = 0; i < 8; i++) begin
			a = a[CRC_W-1] ? ((a << 1) ^ p) : (a << 1);
		end
		return a >> sh;
	endfunction

	function automatic logic [CRC_W-1:0] crc_finalise(
		input logic [CRC_W-1:0] crc,
		input wmode_t           mode,
		input logic             refl,
		input logic [CRC_W-1:0] fxor
	);
		logic [CRC_W-1:0] r;
		r = refl ? reverse_word(crc << align_shift(mode)) : crc;
		return (r ^ fxor) & width_mask(mode);
	endfunction

endpackage

### rtl/ccrc_cfg.sv
`timescale 1ns / 1ps

module ccrc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ccrc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [ccrc_pkg::CRC_W-1:0]        wr_data,
	output ccrc_pkg::cfg_t                    cfg
);

	ccrc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_mode      <= ccrc_pkg::WMODE_32;
			cfg_q.preset_value    <= 32'hFFFF_FFFF;
			cfg_q.polynomial      <= 32'h04C1_1DB7;
			cfg_q.final_xor_value <= 32'hFFFF_FFFF;
			cfg_q.reflect_input   <= 1'b1;
			cfg_q.reflect_output  <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				ccrc_pkg::REG_WIDTH_MODE:  cfg_q.width_mode <= ccrc_pkg::wmode_t'(wr_data[1:0]);
				ccrc_pkg::REG_INITIAL:     cfg_q.preset_value <= wr_data;
				ccrc_pkg::REG_POLYNOMIAL:  cfg_q.polynomial <= wr_data;
				ccrc_pkg::REG_FINAL_XOR:   cfg_q.final_xor_value <= wr_data;
				ccrc_pkg::REG_REFLECT_IN:  cfg_q.reflect_input <= wr_data[0];
				ccrc_pkg::REG_REFLECT_OUT: cfg_q.reflect_output <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/ccrc_core.sv
`timescale 1ns / 1ps

module ccrc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  ccrc_pkg::cfg_t    cfg,
	input  logic              in_en,
	input  logic [7:0]        in_byte,
	input  logic              in_first,
	input  logic              in_last,
	output ccrc_pkg::result_t res
);

	logic [ccrc_pkg::CRC_W-1:0] crc_q;
	logic [ccrc_pkg::CRC_W-1:0] base;
	logic [ccrc_pkg::CRC_W-1:0] crc_next;
	logic [7:0]                 data;

	always_comb begin
		base = in_first ? (cfg.preset_value & ccrc_pkg::width_mask(cfg.width_mode)) : crc_q;
		data = cfg.reflect_input ? ccrc_pkg::reverse8(in_byte) : in_byte;
		crc_next = ccrc_pkg::crc_byte(base, data, cfg.polynomial, cfg.width_mode);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (in_en) begin
			crc_q <= crc_next;
		end
	end

	assign res.valid = in_en;
	assign res.crc   = ccrc_pkg::crc_finalise(crc_next, cfg.width_mode,
		cfg.reflect_output, cfg.final_xor_value);
	assign res.last  = in_last;

endmodule

### rtl/ccrc_out.sv
`timescale 1ns / 1ps

module ccrc_out (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ccrc_pkg::result_t          res,
	output logic                       space,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ccrc_pkg::CRC_W-1:0] m_tdata,
	output logic                       m_tlast
);

	logic                       valid_q;
	logic [ccrc_pkg::CRC_W-1:0] data_q;
	logic                       last_q;

	assign space = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= res.valid;
		end
	end

	// hold the beat while the sink stalls
	always_ff @(posedge clk) begin
		if (space && res.valid) begin
			data_q <= res.crc;
			last_q <= res.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

### rtl/configurable_crc_engine_top.sv
`timescale 1ns / 1ps
// An accepted input beat gives its registered result beat on m_* in the next cycle.
// Throughput: one byte per cycle unless m_* stalls; the running CRC is updated by an
// eight-step XOR-shift network in the same cycle; output register frees as taken.
// Reset: arst_n clears the CRC register to zero, empties the output register
// and loads the CRC-32 defaults into the configuration registers.
module configurable_crc_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ccrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ccrc_pkg::CRC_W-1:0]        cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // data_byte
	input  logic [0:0]                        s_tuser,  // first_byte
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ccrc_pkg::CRC_W-1:0]        m_tdata,  // crc_value
	output logic                              m_tlast
);

	ccrc_pkg::cfg_t    cfg;
	ccrc_pkg::result_t res;
	logic              space;
	logic              in_en;

	assign cfg_ready = 1'b1;
	assign s_tready  = space;
	assign in_en     = s_tvalid && s_tready;

	ccrc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ccrc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_en    (in_en),
		.in_byte  (s_tdata),
		.in_first (s_tuser[0]),
		.in_last  (s_tlast),
		.res      (res)
	);

	ccrc_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while result beat stalled");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_en |=> m_tvalid)
		else $error("accepted beat produced no result");

	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_en |=> (m_tlast == $past(s_tlast)))
		else $error("last marker lost");

	a_crc_fits_width: assert property (@(posedge clk) disable iff (!arst_n)
		(in_en && cfg.width_mode == ccrc_pkg::WMODE_8) |=> (m_tdata[31:8] == 24'd0))
		else $error("8-bit result has high bits set");

endmodule
